// ----- rtl/espl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// espl_pkg: shared constants and types for the encoder speed PID loop
// Register indexes, reset values, field widths and limits.
// ----------------------------------------------------------------------------
package espl_pkg;

    localparam int COUNT_W  = 16;
    localparam int SPEED_W  = 14;
    localparam int ERR_W    = 15;
    localparam int GAIN_W   = 16;
    localparam int DRIVE_W  = 16;
    localparam int ESUM_W   = 32;
    localparam int PROD_W   = GAIN_W + ESUM_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [COUNT_W-1:0] DELTA_LIMIT = 16'd600;
    localparam logic [20:0]        SPEED_MAX   = 21'd16383;
    // ceil(2^18 / 5), exact floor(x/5) for any 16-bit x
    localparam logic [15:0]        RECIP5      = 16'd52429;

    localparam logic [SPEED_W-1:0] TARGET_RST    = 14'd70;
    localparam logic [DRIVE_W-1:0] DRIVE_MIN_RST = 16'h8000;
    localparam logic [DRIVE_W-1:0] DRIVE_MAX_RST = 16'h7FFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET    = 3'd0,
        REG_ENABLE    = 3'd1,
        REG_GAIN_P    = 3'd2,
        REG_GAIN_I    = 3'd3,
        REG_GAIN_D    = 3'd4,
        REG_DRIVE_MIN = 3'd5,
        REG_DRIVE_MAX = 3'd6
    } t_reg_idx;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SPEED = 6'b000010,
        S_INTEG = 6'b000100,
        S_MUL   = 6'b001000,
        S_CLAMP = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    // multiplier operand steps
    localparam logic [1:0] MUL_P    = 2'd0;
    localparam logic [1:0] MUL_I    = 2'd1;
    localparam logic [1:0] MUL_D    = 2'd2;
    localparam logic [1:0] MUL_LAST = 2'd3;

endpackage
`default_nettype wire

// ----- rtl/encoder_speed_pid_loop.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// encoder_speed_pid_loop: wheel speed measurement and PID drive update
// Forms the encoder delta, speed and error, then runs one PID step with a
// single shared 16x32 signed multiplier and clamps the drive output.
// ----------------------------------------------------------------------------
//  channel   ports                                   direction
//  input     i_in_valid / o_in_ready, i_encoder_count    in
//  result    o_out_valid / i_out_ready, o_wheel_speed,
//            o_speed_error, o_drive, o_updated            out
//  config    i_cfg_valid / o_cfg_ready, i_cfg_index,
//            i_cfg_data                                   in
//
//  When the loop is enabled an item passes through speed, integrator, four
//  multiplier/accumulate steps, clamp and output load; when disabled it goes
//  from the speed step straight to the output load.
//  The next item is accepted once the result sits in the output register.
//  Reset is synchronous, active low; it clears state and config to defaults.
//  A stalled output holds the sequencer in its last step until taken.
// ----------------------------------------------------------------------------
module encoder_speed_pid_loop (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [espl_pkg::COUNT_W-1:0]      i_encoder_count,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [espl_pkg::SPEED_W-1:0]           o_wheel_speed,
    output logic signed [espl_pkg::ERR_W-1:0]      o_speed_error,
    output logic signed [espl_pkg::DRIVE_W-1:0]    o_drive,
    output logic                                   o_updated,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [espl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [espl_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // configuration
    logic [espl_pkg::SPEED_W-1:0]          r_target;
    logic                                  r_enable;
    logic signed [espl_pkg::GAIN_W-1:0]    r_gain_p;
    logic signed [espl_pkg::GAIN_W-1:0]    r_gain_i;
    logic signed [espl_pkg::GAIN_W-1:0]    r_gain_d;
    logic signed [espl_pkg::DRIVE_W-1:0]   r_drive_min;
    logic signed [espl_pkg::DRIVE_W-1:0]   r_drive_max;

    // loop state
    logic [espl_pkg::COUNT_W-1:0]          r_last;
    logic signed [espl_pkg::ESUM_W-1:0]    r_esum;
    logic signed [espl_pkg::ERR_W-1:0]     r_prev_err;
    logic signed [espl_pkg::DRIVE_W-1:0]   r_drive_hold;

    // working registers
    espl_pkg::t_state                      r_state;
    logic [espl_pkg::COUNT_W-1:0]          r_count;
    logic [espl_pkg::SPEED_W-1:0]          r_speed;
    logic signed [espl_pkg::ERR_W-1:0]     r_err;
    logic signed [espl_pkg::ERR_W:0]       r_deriv;
    logic [1:0]                            r_step;
    logic signed [espl_pkg::PROD_W-1:0]    r_prod;
    logic signed [espl_pkg::ACC_W-1:0]     r_acc;
    logic                                  r_upd;

    // output register
    logic                                  r_out_valid;
    logic [espl_pkg::SPEED_W-1:0]          r_o_speed;
    logic signed [espl_pkg::ERR_W-1:0]     r_o_err;
    logic signed [espl_pkg::DRIVE_W-1:0]   r_o_drive;
    logic                                  r_o_upd;

    // speed datapath
    logic [espl_pkg::COUNT_W-1:0]          w_delta;
    logic [31:0]                           w_recip;
    logic [20:0]                           w_speed_raw;
    logic [espl_pkg::SPEED_W-1:0]          w_speed;
    logic signed [espl_pkg::ERR_W-1:0]     w_err;

    // integrator
    logic signed [espl_pkg::ESUM_W:0]      w_int;
    logic signed [espl_pkg::ESUM_W-1:0]    w_int_sat;

    // shared multiplier
    logic signed [espl_pkg::GAIN_W-1:0]    w_mul_a;
    logic signed [espl_pkg::ESUM_W-1:0]    w_mul_b;
    logic signed [espl_pkg::PROD_W-1:0]    w_prod;

    // clamp
    logic signed [espl_pkg::ACC_W-9:0]     w_res;
    logic signed [espl_pkg::ACC_W-9:0]     w_hi;
    logic signed [espl_pkg::ACC_W-9:0]     w_lo;
    logic signed [espl_pkg::ACC_W-9:0]     w_res_hi;
    logic signed [espl_pkg::ACC_W-9:0]     w_res_cl;

    logic                                  w_out_free;

    assign o_in_ready    = (r_state == espl_pkg::S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_wheel_speed = r_o_speed;
    assign o_speed_error = r_o_err;
    assign o_drive       = r_o_drive;
    assign o_updated     = r_o_upd;
    assign w_out_free    = !r_out_valid || i_out_ready;

    // speed = 16*delta + floor(delta/5), or zero when delta exceeds DELTA_LIMIT
    always_comb begin
        w_delta     = r_count - r_last;
        w_recip     = w_delta * espl_pkg::RECIP5;
        w_speed_raw = {1'b0, w_delta, 4'b0000} + {7'd0, w_recip[31:18]};
        if (w_delta > espl_pkg::DELTA_LIMIT) begin
            w_speed = '0;
        end else if (w_speed_raw > espl_pkg::SPEED_MAX) begin
            w_speed = espl_pkg::SPEED_MAX[espl_pkg::SPEED_W-1:0];
        end else begin
            w_speed = w_speed_raw[espl_pkg::SPEED_W-1:0];
        end
        w_err = $signed({1'b0, r_target}) - $signed({1'b0, w_speed});
    end

    always_comb begin
        w_int = {r_esum[espl_pkg::ESUM_W-1], r_esum}
              + {{(espl_pkg::ESUM_W-espl_pkg::ERR_W+1){r_err[espl_pkg::ERR_W-1]}}, r_err};
        if (w_int[espl_pkg::ESUM_W] != w_int[espl_pkg::ESUM_W-1]) begin
            w_int_sat = w_int[espl_pkg::ESUM_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            w_int_sat = w_int[espl_pkg::ESUM_W-1:0];
        end
    end

    always_comb begin
        case (r_step)
            espl_pkg::MUL_P: begin
                w_mul_a = r_gain_p;
                w_mul_b = {{(espl_pkg::ESUM_W-espl_pkg::ERR_W){r_err[espl_pkg::ERR_W-1]}},
                           r_err};
            end
            espl_pkg::MUL_I: begin
                w_mul_a = r_gain_i;
                w_mul_b = r_esum;
            end
            espl_pkg::MUL_D: begin
                w_mul_a = r_gain_d;
                w_mul_b = {{(espl_pkg::ESUM_W-espl_pkg::ERR_W-1){r_deriv[espl_pkg::ERR_W]}},
                           r_deriv};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
        w_prod = w_mul_a * w_mul_b;
    end

    // floor(sum/256) is the upper bits; upper clamp first, then lower
    always_comb begin
        w_res    = r_acc[espl_pkg::ACC_W-1:8];
        w_hi     = {{(espl_pkg::ACC_W-8-espl_pkg::DRIVE_W){r_drive_max[espl_pkg::DRIVE_W-1]}},
                    r_drive_max};
        w_lo     = {{(espl_pkg::ACC_W-8-espl_pkg::DRIVE_W){r_drive_min[espl_pkg::DRIVE_W-1]}},
                    r_drive_min};
        w_res_hi = (w_res > w_hi) ? w_hi : w_res;
        w_res_cl = (w_res_hi < w_lo) ? w_lo : w_res_hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= espl_pkg::TARGET_RST;
            r_enable    <= 1'b0;
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_drive_min <= espl_pkg::DRIVE_MIN_RST;
            r_drive_max <= espl_pkg::DRIVE_MAX_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                espl_pkg::REG_TARGET:    r_target    <= i_cfg_data[espl_pkg::SPEED_W-1:0];
                espl_pkg::REG_ENABLE:    r_enable    <= i_cfg_data[0];
                espl_pkg::REG_GAIN_P:    r_gain_p    <= i_cfg_data;
                espl_pkg::REG_GAIN_I:    r_gain_i    <= i_cfg_data;
                espl_pkg::REG_GAIN_D:    r_gain_d    <= i_cfg_data;
                espl_pkg::REG_DRIVE_MIN: r_drive_min <= i_cfg_data;
                espl_pkg::REG_DRIVE_MAX: r_drive_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= espl_pkg::S_IDLE;
            r_last       <= '0;
            r_esum       <= '0;
            r_prev_err   <= '0;
            r_drive_hold <= '0;
            r_out_valid  <= 1'b0;
            r_step       <= '0;
            r_upd        <= 1'b0;
        end else begin
            // S_DONE reloads the output register on its own
            if (r_out_valid && i_out_ready && (r_state != espl_pkg::S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                espl_pkg::S_IDLE: begin
                    if (i_in_valid) begin
                        r_count <= i_encoder_count;
                        r_state <= espl_pkg::S_SPEED;
                    end
                end
                espl_pkg::S_SPEED: begin
                    r_last  <= r_count;
                    r_speed <= w_speed;
                    r_err   <= w_err;
                    r_upd   <= 1'b0;
                    r_state <= r_enable ? espl_pkg::S_INTEG : espl_pkg::S_DONE;
                end
                espl_pkg::S_INTEG: begin
                    r_esum  <= w_int_sat;
                    r_deriv <= {r_err[espl_pkg::ERR_W-1], r_err}
                             - {r_prev_err[espl_pkg::ERR_W-1], r_prev_err};
                    r_acc   <= '0;
                    r_step  <= espl_pkg::MUL_P;
                    r_state <= espl_pkg::S_MUL;
                end
                espl_pkg::S_MUL: begin
                    // product registered, added one step later
                    r_prod <= w_prod;
                    if (r_step != espl_pkg::MUL_P) begin
                        r_acc <= r_acc + {{2{r_prod[espl_pkg::PROD_W-1]}}, r_prod};
                    end
                    r_step <= r_step + 2'd1;
                    if (r_step == espl_pkg::MUL_LAST) begin
                        r_state <= espl_pkg::S_CLAMP;
                    end
                end
                espl_pkg::S_CLAMP: begin
                    r_drive_hold <= w_res_cl[espl_pkg::DRIVE_W-1:0];
                    r_prev_err   <= r_err;
                    r_upd        <= 1'b1;
                    r_state      <= espl_pkg::S_DONE;
                end
                espl_pkg::S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_speed   <= r_speed;
                        r_o_err     <= r_err;
                        r_o_drive   <= r_drive_hold;
                        r_o_upd     <= r_upd;
                        r_state     <= espl_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= espl_pkg::S_IDLE;
                end
            endcase
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == espl_pkg::S_SPEED))
        else $error("accepted item did not start the speed step");

    a_esum_only_in_integ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != espl_pkg::S_INTEG) |=> $stable(r_esum))
        else $error("integrator changed outside its step");

    a_clamp_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == espl_pkg::S_CLAMP) |-> ($past(r_state) == espl_pkg::S_MUL
                                            && $past(r_step) == espl_pkg::MUL_LAST))
        else $error("clamp reached without all multiply steps");

    a_drive_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_updated) |-> (o_drive >= r_drive_min)
                                        && ((o_drive <= r_drive_max)
                                            || (o_drive == r_drive_min)))
        else $error("updated drive outside clamp limits");

endmodule
`default_nettype wire
